[design/eefa_pkg.sv]
// Package for the extended-exponent float ALU: beat types, command codes, constants.
// No dependencies.
package eefa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_CONV = 2'd2,
    CMD_MULF = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        a_significand;
    logic signed [31:0] a_exponent;
    logic [31:0]        b_significand;
    logic signed [31:0] b_exponent;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]        result_significand;
    logic signed [31:0] result_exponent;
  } out_beat_t;

  localparam logic [31:0] KeepMask  = 32'h807F_FFFF;
  localparam logic [31:0] OneField  = 32'h3F80_0000;
  localparam logic [31:0] CanonNan  = 32'h7FC0_0000;
  localparam logic [31:0] Sixteen   = 32'h4180_0000;
  localparam logic [31:0] Sixteenth = 32'h3D80_0000;
  localparam logic [7:0]  Bias      = 8'd127;
  localparam int          MaxShift  = 31;
  localparam int          FracBits  = 23;

  // Unbiased exponent of a float pattern as a 32-bit delta
  function automatic logic [31:0] exp_delta(input logic [31:0] f);
    exp_delta = {24'd0, f[30:23]} - {24'd0, Bias};
  endfunction

  // Lazy renormalise check: f negative or zero, or f >= 16 or f <= 1/16 (NaN never qualifies)
  function automatic logic needs_norm(input logic [31:0] f);
    logic is_nan;
    logic is_zero;
    is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    is_zero = (f[30:0] == 31'd0);
    if (is_nan) needs_norm = 1'b0;
    else if (f[31] || is_zero) needs_norm = 1'b1;
    else needs_norm = (f[30:0] >= Sixteen[30:0]) || (f[30:0] <= Sixteenth[30:0]);
  endfunction

endpackage

[design/extended_exponent_float_alu_top.sv]
// Top level of the extended-exponent float ALU: command decode, alignment, output stage.
// Depends on eefa_pkg and eefa_fpcore.
// A beat passes the input decode register and then the four-stage float core (unpack,
// multiply/align, normalise and round, lazy renormalise) before it is offered on the
// output, and one beat is accepted every cycle while the pipeline advances.
// The whole pipeline advances when the output register is empty or being taken.
module extended_exponent_float_alu_top import eefa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- decode stage
  typedef struct packed {
    logic        mul;
    logic [31:0] x, y, exp;
    logic        bypass;
    logic [31:0] bsig;
    logic        norm;
  } dec_t;

  dec_t dec_d, dec_q;
  logic dv_q;

  always_comb begin
    logic [31:0] d;
    logic [31:0] zs;
    d = in_data_i.a_exponent - in_data_i.b_exponent;
    zs = (in_data_i.b_significand & KeepMask) | OneField;
    dec_d = '0;
    dec_d.x = in_data_i.a_significand;
    dec_d.exp = in_data_i.a_exponent;
    case (cmd_e'(in_data_i.command))
      CMD_ADD: begin
        dec_d.mul = 1'b0;
        if ($signed(d) > MaxShift) begin
          dec_d.bypass = 1'b1; dec_d.bsig = in_data_i.a_significand;
        end else if ($signed(d) < -MaxShift) begin
          dec_d.bypass = 1'b1; dec_d.bsig = in_data_i.b_significand;
          dec_d.exp = in_data_i.b_exponent;
        end else if (!d[31]) begin
          dec_d.y = in_data_i.b_significand - (d << FracBits);
        end else begin
          dec_d.y = in_data_i.b_significand + ((32'd0 - d) << FracBits);
        end
      end
      CMD_MUL: begin
        dec_d.mul = 1'b1;
        dec_d.y = in_data_i.b_significand;
        dec_d.exp = in_data_i.a_exponent + in_data_i.b_exponent;
      end
      CMD_CONV: begin
        dec_d.bypass = 1'b1;
        dec_d.bsig = in_data_i.a_significand;
        dec_d.exp = 32'd0;
        dec_d.norm = 1'b1;
      end
      default: begin
        dec_d.mul = 1'b1;
        dec_d.y = zs;
        dec_d.exp = in_data_i.a_exponent + exp_delta(in_data_i.b_significand);
      end
    endcase
  end

  // convert: renormalise the bypassed pattern in the last stage
  logic        cv;
  logic [31:0] csig, cexp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= 1'b0;
    else if (adv) dv_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) dec_q <= dec_d;
  end

  eefa_fpcore u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (dv_q),
    .mul_i    (dec_q.mul),
    .x_i      (dec_q.x),
    .y_i      (dec_q.y),
    .exp_i    (dec_q.exp),
    .bypass_i (dec_q.bypass),
    .bsig_i   (dec_q.bsig),
    .norm_i   (dec_q.norm),
    .valid_o  (cv),
    .sig_o    (csig),
    .exp_o    (cexp)
  );

  assign out_valid_o = cv;
  assign out_data_o.result_significand = csig;
  assign out_data_o.result_exponent = cexp;

`ifndef SYNTHESIS
  // a held output beat must not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");
  // input ready follows the output stage
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output stage");
`endif

endmodule

[design/eefa_fpcore.sv]
// Pipelined float32 add / multiply core, round to nearest even, subnormals kept.
// Depends on eefa_pkg. Four register stages, one beat per cycle, stall by enable.
module eefa_fpcore import eefa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic        mul_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] exp_i,
  input  logic        bypass_i,
  input  logic [31:0] bsig_i,
  input  logic        norm_i,
  output logic        valid_o,
  output logic [31:0] sig_o,
  output logic [31:0] exp_o
);

  // ---------------- stage 1: unpack and classify
  typedef struct packed {
    logic        mul;
    logic        sx, sy;
    logic [9:0]  ex, ey;   // effective exponent (subnormal uses 1)
    logic [23:0] mx, my;
    logic        nan, inf, infsign;
    logic [31:0] exp;
    logic        bypass;
    logic [31:0] bsig;
    logic        norm;
  } s1_t;

  s1_t s1_d, s1_q;
  logic v1_q;

  always_comb begin
    logic xn, yn, xi, yi, xz, yz;
    xn = (x_i[30:23] == 8'hFF) && (x_i[22:0] != 0);
    yn = (y_i[30:23] == 8'hFF) && (y_i[22:0] != 0);
    xi = (x_i[30:23] == 8'hFF) && (x_i[22:0] == 0);
    yi = (y_i[30:23] == 8'hFF) && (y_i[22:0] == 0);
    xz = (x_i[30:0] == 0);
    yz = (y_i[30:0] == 0);
    s1_d.mul = mul_i;
    s1_d.sx = x_i[31];
    s1_d.sy = y_i[31];
    s1_d.ex = {2'b0, (x_i[30:23] == 0) ? 8'd1 : x_i[30:23]};
    s1_d.ey = {2'b0, (y_i[30:23] == 0) ? 8'd1 : y_i[30:23]};
    s1_d.mx = {(x_i[30:23] != 0), x_i[22:0]};
    s1_d.my = {(y_i[30:23] != 0), y_i[22:0]};
    if (mul_i) begin
      s1_d.nan = xn || yn || (xi && yz) || (yi && xz);
      s1_d.inf = xi || yi;
      s1_d.infsign = x_i[31] ^ y_i[31];
    end else begin
      s1_d.nan = xn || yn || (xi && yi && (x_i[31] != y_i[31]));
      s1_d.inf = xi || yi;
      s1_d.infsign = xi ? x_i[31] : y_i[31];
    end
    s1_d.exp = exp_i;
    s1_d.bypass = bypass_i;
    s1_d.bsig = bsig_i;
    s1_d.norm = norm_i;
  end

  // ---------------- stage 2: multiply or align, to a wide signed mantissa
  // man bit 49 carries the biased float exponent e (sticky in lsb)
  typedef struct packed {
    logic        sign;
    logic signed [11:0] e;  // exponent of man bit 49 as a biased float exponent
    logic [49:0] man;       // bits 49..1 data, bit 0 sticky
    logic        exzero;    // exact zero result
    logic        zsign;
    logic        nan, inf, infsign;
    logic [31:0] exp;
    logic        bypass;
    logic [31:0] bsig;
    logic        norm;
  } s2_t;

  s2_t s2_d, s2_q;
  logic v2_q;

  always_comb begin
    logic [47:0] prod;
    logic [9:0]  diff;
    logic [73:0] big, lesser;
    logic [73:0] sh;
    logic        bsx, bss;
    logic [9:0]  be;
    logic [74:0] sum;
    logic        sticky;
    prod = s1_q.mx * s1_q.my;
    big = '0; lesser = '0; sh = '0; bsx = 0; bss = 0; be = '0; sum = '0;
    sticky = 0; diff = '0;
    s2_d = '0;
    s2_d.nan = s1_q.nan;
    s2_d.inf = s1_q.inf;
    s2_d.infsign = s1_q.infsign;
    s2_d.exp = s1_q.exp;
    s2_d.bypass = s1_q.bypass;
    s2_d.bsig = s1_q.bsig;
    s2_d.norm = s1_q.norm;
    if (s1_q.mul) begin
      // product bit 47 is man bit 49, biased exponent ex+ey-126
      s2_d.sign = s1_q.sx ^ s1_q.sy;
      s2_d.e = $signed({2'b0, s1_q.ex}) + $signed({2'b0, s1_q.ey}) - 12'sd126;
      s2_d.man = {prod, 2'b0};
      s2_d.exzero = (prod == 0);
      s2_d.zsign = s1_q.sx ^ s1_q.sy;
    end else begin
      // align in a 74-bit frame: mantissa at bits 73..50, shifted bits below
      if ({s1_q.ex, s1_q.mx} >= {s1_q.ey, s1_q.my}) begin
        big = {s1_q.mx, 50'd0}; lesser = {s1_q.my, 50'd0};
        diff = s1_q.ex - s1_q.ey; be = s1_q.ex; bsx = s1_q.sx; bss = s1_q.sy;
      end else begin
        big = {s1_q.my, 50'd0}; lesser = {s1_q.mx, 50'd0};
        diff = s1_q.ey - s1_q.ex; be = s1_q.ey; bsx = s1_q.sy; bss = s1_q.sx;
      end
      if (diff > 10'd48) begin
        sh = '0; sticky = (lesser != 0);
      end else begin
        sh = lesser >> diff;
        sticky = ((sh << diff) != lesser);
      end
      if (bsx == bss) sum = {1'b0, big} + {1'b0, sh};
      else sum = {1'b0, big} - {1'b0, sh} - {74'd0, sticky};
      // sum bit 73 has biased exponent be; sum bit 74 is man bit 49 at be+1
      s2_d.sign = bsx;
      s2_d.e = $signed({2'b0, be}) + 12'sd1;
      s2_d.man = {sum[74:26], (sum[25:0] != 0) || sticky};
      s2_d.exzero = (sum == 0) && !sticky;
      s2_d.zsign = s1_q.sx & s1_q.sy;
    end
  end

  // ---------------- stage 3: normalise (leading one search) and round
  typedef struct packed {
    logic [31:0] res;
    logic [31:0] exp;
    logic        bypass;
    logic [31:0] bsig;
    logic        norm;
  } s3_t;

  s3_t s3_d, s3_q;
  logic v3_q;

  always_comb begin
    logic [5:0]  lz;
    logic signed [12:0] en;
    logic [49:0] m;
    logic [6:0]  rsh;
    logic [49:0] mr;
    logic        st;
    logic [24:0] rm;
    logic        g, rb, lsb;
    logic signed [12:0] ef;
    logic [31:0] r;
    lz = 6'd49;
    for (int i = 0; i < 49; i++) if (s2_q.man[49 - i] && lz == 6'd49) lz = 6'(i);
    // man bit 49 ~ biased exponent e ... bring leading one to bit 49
    m = s2_q.man << lz;
    en = 13'(s2_q.e) - 13'(signed'({7'd0, lz}));
    rsh = 7'd0;
    if (en < 13'sd1) rsh = (13'sd1 - en > 13'sd40) ? 7'd40 : 7'(13'sd1 - en);
    mr = m >> rsh;
    st = ((mr << rsh) != m);
    if (en < 13'sd1) en = 13'sd0;
    rm = {1'b0, mr[49:26]};
    g = mr[25];
    rb = (mr[24:0] != 0) || st;
    lsb = mr[26];
    if (g && (rb || lsb)) rm = rm + 25'd1;
    ef = en;
    if (rm[24]) begin
      rm = rm >> 1; ef = ef + 13'sd1;
    end else if (en == 13'sd0 && rm[23]) ef = 13'sd1;
    if (s2_q.nan) r = CanonNan;
    else if (s2_q.inf) r = {s2_q.infsign, 8'hFF, 23'd0};
    else if (s2_q.exzero) r = {s2_q.zsign, 31'd0};
    else if (ef >= 13'sd255) r = {s2_q.sign, 8'hFF, 23'd0};
    else r = {s2_q.sign, ef[7:0], rm[22:0]};
    s3_d.res = r;
    s3_d.exp = s2_q.exp;
    s3_d.bypass = s2_q.bypass;
    s3_d.bsig = s2_q.bsig;
    s3_d.norm = s2_q.norm;
  end

  // ---------------- stage 4: lazy renormalise, or bypass (forced one if norm set)
  logic [31:0] sig_d, sig_q, exq_d, exq_q;
  logic v4_q;

  always_comb begin
    sig_d = s3_q.res;
    exq_d = s3_q.exp;
    if (s3_q.bypass) begin
      sig_d = s3_q.bsig;
      if (s3_q.norm) begin
        exq_d = s3_q.exp + exp_delta(s3_q.bsig);
        sig_d = (s3_q.bsig & KeepMask) | OneField;
      end
    end else if (needs_norm(s3_q.res)) begin
      exq_d = s3_q.exp + exp_delta(s3_q.res);
      sig_d = (s3_q.res & KeepMask) | OneField;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d;
      sig_q <= sig_d; exq_q <= exq_d;
    end
  end

  assign valid_o = v4_q;
  assign sig_o = sig_q;
  assign exp_o = exq_q;

endmodule
